### hdl/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg
// shared types and constants of the log stream deframer
// ----------------------------------------------------------------------------
package lsd_pkg;

	// request codes
	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_EOS  = 1'b1;

	// configuration register indexes
	localparam logic CFG_IDX_TTY_MODE    = 1'b0;
	localparam logic CFG_IDX_MAX_PAYLOAD = 1'b1;

	localparam logic [31:0] MAX_PAYLOAD_RST = 32'd65536;

	localparam logic [7:0] NEWLINE_CHAR = 8'h0a;
	localparam logic [3:0] HEADER_LEN   = 4'd8;
	localparam logic [3:0] LEN_FIRST    = 4'd4;
	localparam logic [7:0] STREAM_OUT   = 8'd1;
	localparam logic [7:0] STREAM_ERR   = 8'd2;

	// one result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       stream_id;
		logic       last;
		logic       truncated;
	} result_t;

	// deframer state
	typedef struct packed {
		logic [3:0]  header_count;
		logic [7:0]  frame_stream_type;
		logic [31:0] remaining;
		logic        skipping;
		logic        message_open;
	} dfr_state_t;

endpackage

### hdl/log_stream_deframer_top.sv
// ----------------------------------------------------------------------------
// log_stream_deframer_top
// splits a log byte stream into messages, by newline or by 8-byte frame header
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    req_type, in_byte
//  output    out        out_valid / out_stall  out_byte, has_byte, stream_id,
//                                              last, truncated
//  config    in         cfg_wen                cfg_index, cfg_wdata
//
//  one byte per cycle sustained while the output is not stalled; a byte is
//  captured in the input register and its result in the output register
//  the rate is set by the single state update per byte in lsd_core
//  reset clears the deframer state and loads the register defaults
//  a stall on the output holds the input register, which then stalls the input
//  bytes that give no result (header, skipped payload) still pass through the input register
//
module log_stream_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  in_byte,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        has_byte,
	output logic        stream_id,
	output logic        last,
	output logic        truncated,
	// configuration write port
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);
	import lsd_pkg::*;

	// configuration registers
	logic        tty_mode_q;
	logic [31:0] max_payload_q;

	// input register
	logic        valid_s1;
	logic        req_s1;
	logic [7:0]  byte_s1;

	// result register
	logic        out_valid_q;
	result_t     res_q;

	// core handshake
	logic        out_ready;
	logic        process;
	logic        res_valid;
	result_t     res;

	// the result register is free or emptied in this cycle
	assign out_ready = !out_valid_q || !out_stall;
	// the byte in the input register is decided when its result has a place
	assign process   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tty_mode_q    <= 1'b0;
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_IDX_TTY_MODE:    tty_mode_q    <= cfg_wdata[0];
				CFG_IDX_MAX_PAYLOAD: max_payload_q <= cfg_wdata;
				default:             ;
			endcase
		end
	end

	// input register, loads whenever it is not held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_s1  <= req_type;
			byte_s1 <= in_byte;
		end
	end

	lsd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.process     (process),
		.req_type    (req_s1),
		.in_byte     (byte_s1),
		.tty_mode    (tty_mode_q),
		.max_payload (max_payload_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	// result register, a transaction leaves it when out_stall is low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= process && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (process && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = res_q.out_byte;
	assign has_byte  = res_q.has_byte;
	assign stream_id = res_q.stream_id;
	assign last      = res_q.last;
	assign truncated = res_q.truncated;

	// a truncation marker is a bare end marker
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.truncated) |-> (res_q.last && !res_q.has_byte))
		else $error("truncated result is not a bare end marker");

	// a bare end marker carries no byte and closes the message
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.has_byte) |-> (res_q.last && res_q.out_byte == '0))
		else $error("bare marker malformed");

	// a held input byte is still there on the next edge
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (valid_s1 && $stable(byte_s1) && $stable(req_s1)))
		else $error("input register lost a held transaction");

	// a held result is not overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(res_q)))
		else $error("result register overwritten while stalled");

endmodule

### hdl/lsd_core.sv
// ----------------------------------------------------------------------------
// lsd_core
// deframer state and the per-byte decision logic
// ----------------------------------------------------------------------------
module lsd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             process,
	input  logic             req_type,
	input  logic [7:0]       in_byte,
	input  logic             tty_mode,
	input  logic [31:0]      max_payload,
	output logic             res_valid,
	output lsd_pkg::result_t res
);
	import lsd_pkg::*;

	dfr_state_t st_q;
	dfr_state_t st_d;

	logic        hdr_path;
	logic [3:0]  hc_w;
	logic [3:0]  hc_n;
	logic [31:0] rem_w;
	logic [7:0]  ft_w;
	logic [31:0] rem_dec;
	logic        done;
	logic        known;
	logic        skip_n;

	always_comb begin
		st_d      = st_q;
		res_valid = 1'b0;
		res       = '0;
		hdr_path  = 1'b0;
		hc_w      = st_q.header_count;
		hc_n      = '0;
		rem_w     = st_q.remaining;
		ft_w      = st_q.frame_stream_type;
		rem_dec   = st_q.remaining - 32'd1;
		done      = (rem_dec == '0);
		known     = 1'b0;
		skip_n    = 1'b0;

		if (req_type == REQ_EOS) begin
			if (st_q.message_open) begin
				res_valid = 1'b1;
				res.last  = 1'b1;
				if (!tty_mode) begin
					res.stream_id = (st_q.frame_stream_type == STREAM_ERR);
					res.truncated = 1'b1;
				end
			end
			st_d = '0;
		end else if (tty_mode) begin
			res_valid = 1'b1;
			if (in_byte == NEWLINE_CHAR) begin
				st_d.message_open = 1'b0;
				res.last          = 1'b1;
			end else begin
				st_d.message_open = 1'b1;
				res.out_byte      = in_byte;
				res.has_byte      = 1'b1;
			end
		end else begin
			hdr_path = 1'b1;
			if (st_q.header_count >= HEADER_LEN) begin
				if (st_q.remaining != '0) begin
					hdr_path       = 1'b0;
					st_d.remaining = rem_dec;
					if (done) begin
						st_d.header_count = '0;
						st_d.skipping     = 1'b0;
						st_d.message_open = 1'b0;
					end
					if (!st_q.skipping) begin
						res_valid     = 1'b1;
						res.out_byte  = in_byte;
						res.has_byte  = 1'b1;
						res.stream_id = (st_q.frame_stream_type == STREAM_ERR);
						res.last      = done;
					end
				end else begin
					// payload over, byte starts a new header
					hc_w              = '0;
					st_d.skipping     = 1'b0;
					st_d.message_open = 1'b0;
				end
			end

			if (hdr_path) begin
				if (hc_w == '0) begin
					ft_w  = in_byte;
					rem_w = '0;
				end else if (hc_w >= LEN_FIRST) begin
					rem_w = {rem_w[23:0], in_byte};
				end
				hc_n                   = hc_w + 4'd1;
				st_d.frame_stream_type = ft_w;
				st_d.remaining         = rem_w;
				st_d.header_count      = hc_n;
				if (hc_n == HEADER_LEN) begin
					known  = (ft_w == STREAM_OUT) || (ft_w == STREAM_ERR);
					skip_n = (rem_w > max_payload) || !known;
					if (rem_w == '0) begin
						st_d.header_count = '0;
						st_d.skipping     = 1'b0;
						st_d.message_open = 1'b0;
						if (known) begin
							res_valid     = 1'b1;
							res.stream_id = (ft_w == STREAM_ERR);
							res.last      = 1'b1;
						end
					end else begin
						st_d.skipping     = skip_n;
						st_d.message_open = !skip_n;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (process) begin
			st_q <= st_d;
		end
	end

	// the header count never passes the header length
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.header_count <= HEADER_LEN)
		else $error("header count out of range");

	// the open-message flag does not change inside a header
	assert property (@(posedge clk) disable iff (!arst_n)
		(!tty_mode && st_q.header_count != '0 && st_q.header_count < HEADER_LEN &&
		 $past(!tty_mode) && $past(st_q.header_count) < HEADER_LEN &&
		 $past(st_q.header_count) != '0) |-> st_q.message_open == $past(st_q.message_open))
		else $error("message state changed inside a header");

	// end of stream always returns to the idle state
	assert property (@(posedge clk) disable iff (!arst_n)
		(process && req_type == REQ_EOS) |=> (st_q == '0))
		else $error("state not cleared after end of stream");

endmodule

### test/lsd_tb_pkg.sv
// ----------------------------------------------------------------------------
// lsd_tb_pkg
// scoreboard for the log stream deframer: predicts each message item from the
// accepted input transactions and checks the output transactions in order
// ----------------------------------------------------------------------------
package lsd_tb_pkg;

	import lsd_pkg::*;

	class deframer_scoreboard;

		// register copies
		bit          line_mode;
		bit [31:0]   payload_limit;

		// deframer state copy
		bit [3:0]    hdr_cnt;
		bit [7:0]    frame_type;
		bit [31:0]   bytes_left;
		bit          dropping;
		bit          msg_open;

		result_t     due_items[$];
		int unsigned fails;

		function new();
			line_mode     = 1'b0;
			payload_limit = MAX_PAYLOAD_RST;
			fails         = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			hdr_cnt    = '0;
			frame_type = '0;
			bytes_left = '0;
			dropping   = 1'b0;
			msg_open   = 1'b0;
		endfunction

		function void write_reg(logic idx, logic [31:0] val);
			if (idx == CFG_IDX_TTY_MODE) begin
				line_mode = val[0];
			end else begin
				payload_limit = val;
			end
		endfunction

		function bit err_stream();
			return frame_type == STREAM_ERR;
		endfunction

		function int unsigned outstanding();
			return due_items.size();
		endfunction

		function string show(result_t r);
			return $sformatf("byte %02h has %0b sid %0b last %0b trunc %0b",
				r.out_byte, r.has_byte, r.stream_id, r.last, r.truncated);
		endfunction

		function void flag(string msg);
			fails++;
			if (fails <= 10) begin
				$display("%0t: %s", $time, msg);
			end
		endfunction

		// works out the message item, if any, caused by one input transaction
		function void note_request(logic rt, logic [7:0] b);
			result_t r;
			bit      hit;
			bit      known;
			r   = '0;
			hit = 1'b0;
			if (rt == REQ_EOS) begin
				if (msg_open) begin
					hit    = 1'b1;
					r.last = 1'b1;
					if (!line_mode) begin
						r.stream_id = err_stream();
						r.truncated = 1'b1;
					end
				end
				clear_frame();
			end else if (line_mode) begin
				hit = 1'b1;
				if (b == NEWLINE_CHAR) begin
					msg_open = 1'b0;
					r.last   = 1'b1;
				end else begin
					msg_open   = 1'b1;
					r.out_byte = b;
					r.has_byte = 1'b1;
				end
			end else if (hdr_cnt >= HEADER_LEN && bytes_left != 0) begin
				// payload byte
				bytes_left--;
				if (!dropping) begin
					hit         = 1'b1;
					r.out_byte  = b;
					r.has_byte  = 1'b1;
					r.stream_id = err_stream();
					r.last      = (bytes_left == 0);
				end
				if (bytes_left == 0) begin
					hdr_cnt  = '0;
					dropping = 1'b0;
					msg_open = 1'b0;
				end
			end else begin
				// header byte
				if (hdr_cnt >= HEADER_LEN) begin
					hdr_cnt  = '0;
					dropping = 1'b0;
					msg_open = 1'b0;
				end
				if (hdr_cnt == 0) begin
					frame_type = b;
					bytes_left = '0;
				end else if (hdr_cnt >= LEN_FIRST) begin
					bytes_left = {bytes_left[23:0], b};
				end
				hdr_cnt++;
				if (hdr_cnt == HEADER_LEN) begin
					known    = (frame_type == STREAM_OUT) || (frame_type == STREAM_ERR);
					dropping = (bytes_left > payload_limit) || !known;
					if (bytes_left == 0) begin
						hdr_cnt  = '0;
						dropping = 1'b0;
						msg_open = 1'b0;
						if (known) begin
							hit         = 1'b1;
							r.stream_id = err_stream();
							r.last      = 1'b1;
						end
					end else begin
						msg_open = !dropping;
					end
				end
			end
			if (hit) begin
				due_items.push_back(r);
			end
		endfunction

		function void check_message_item(result_t got);
			result_t want;
			if (due_items.size() == 0) begin
				flag({"unexpected item: ", show(got)});
				return;
			end
			want = due_items.pop_front();
			if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
					got.stream_id !== want.stream_id || got.last !== want.last ||
					got.truncated !== want.truncated) begin
				flag({"mismatch: expected ", show(want), ", got ", show(got)});
			end
		endfunction

		function void close_run();
			if (due_items.size() != 0) begin
				flag($sformatf("%0d items never arrived", due_items.size()));
			end
		endfunction

	endclass

endpackage

### test/tb_log_stream_deframer_top.sv
// ----------------------------------------------------------------------------
// tb_log_stream_deframer_top
// drives byte streams in line mode and in framed mode through the deframer,
// with random gaps and stalls, and checks every message item in order
// ----------------------------------------------------------------------------
module tb_log_stream_deframer_top;

	timeunit 1ns;
	timeprecision 1ps;

	import lsd_pkg::*;
	import lsd_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASE_ITEMS = 120;
	localparam int unsigned SETTLE      = 4;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        req_type  = REQ_DATA;
	logic [7:0]  in_byte   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        has_byte;
	logic        stream_id;
	logic        last;
	logic        truncated;
	logic        cfg_wen   = 1'b0;
	logic        cfg_index = CFG_IDX_TTY_MODE;
	logic [31:0] cfg_wdata = '0;

	deframer_scoreboard sb;
	bit          steady     = 1'b0;  // no gaps and no stalls while set
	int unsigned sent_count = 0;
	int unsigned cycles     = 0;

	log_stream_deframer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.stream_id (stream_id),
		.last      (last),
		.truncated (truncated),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver back-pressure, with a probability of roughly 28 in a hundred
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 28);
	end

	// output monitor: values read here are the ones present at the edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_message_item({out_byte, has_byte, stream_id, last, truncated});
		end
	end

	// one input transaction, with a random gap before it
	task automatic send_item(logic rt, logic [7:0] b);
		while (!steady && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_request(rt, b);
		sent_count++;
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item(REQ_DATA, b);
	endtask

	// end of stream carries a random, ignored byte
	task automatic send_eos();
		send_item(REQ_EOS, 8'($urandom()));
	endtask

	// 8-byte header: stream type, three ignored bytes, big-endian length
	task automatic send_header(logic [7:0] stype, logic [31:0] len);
		send_byte(stype);
		repeat (3) send_byte(8'($urandom()));
		send_byte(len[31:24]);
		send_byte(len[23:16]);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
	endtask

	// both registers, one after the other, once the predicted items have drained
	task automatic set_mode(bit tty, logic [31:0] limit);
		logic [31:0] wd;
		wd    = $urandom();
		wd[0] = tty;  // upper bits are junk and must be ignored
		cfg_wen   <= 1'b1;
		cfg_index <= CFG_IDX_TTY_MODE;
		cfg_wdata <= wd;
		@(posedge clk);
		sb.write_reg(CFG_IDX_TTY_MODE, wd);
		cfg_index <= CFG_IDX_MAX_PAYLOAD;
		cfg_wdata <= limit;
		@(posedge clk);
		sb.write_reg(CFG_IDX_MAX_PAYLOAD, limit);
		cfg_wen <= 1'b0;
	endtask

	// wait for every predicted item, then let bytes with no result flush through
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly well-formed frames with random content; some noise and cut-offs
	task automatic framed_sequence();
		logic [7:0]  stype;
		logic [31:0] len;
		int unsigned pick;
		int unsigned n_send;
		pick = $urandom_range(99);
		if (pick < 4) begin
			send_eos();
		end else if (pick < 8) begin
			send_byte(8'($urandom()));  // knocks the header out of step
		end
		pick = $urandom_range(99);
		if (pick < 45) begin
			stype = STREAM_OUT;
		end else if (pick < 85) begin
			stype = STREAM_ERR;
		end else begin
			stype = 8'($urandom());  // mostly suppressed frames
		end
		pick = $urandom_range(99);
		if (pick < 10) begin
			len = '0;
		end else if (pick < 70) begin
			len = $urandom_range(12, 1);
		end else if (pick < 80) begin
			// right on or just over the limit where that is short enough to send
			if (sb.payload_limit <= 40) begin
				len = sb.payload_limit + $urandom_range(1);
			end else begin
				len = $urandom_range(40, 13);
			end
		end else if (pick < 90) begin
			len = $urandom_range(40, 13);
		end else begin
			len = $urandom();  // far too long to send whole
		end
		send_header(stype, len);
		if (len > 40) begin
			n_send = $urandom_range(6);
		end else if (len != 0 && $urandom_range(9) == 0) begin
			n_send = $urandom_range(len - 1);
		end else begin
			n_send = len;
		end
		repeat (n_send) send_byte(8'($urandom()));
		if (n_send < len || $urandom_range(19) == 0) begin
			send_eos();
		end
	endtask

	// a line of random bytes, usually closed by a newline
	task automatic line_sequence();
		int unsigned pick;
		repeat ($urandom_range(10)) send_byte(8'($urandom()));
		pick = $urandom_range(99);
		if (pick < 80) begin
			send_byte(NEWLINE_CHAR);
		end else if (pick < 92) begin
			send_eos();
		end
	endtask

	// one random phase; it may end mid-message so the next setting sees live state
	task automatic random_phase(bit tty, logic [31:0] limit, bit no_idle);
		int unsigned start;
		drain();
		set_mode(tty, limit);
		steady = no_idle;
		start  = sent_count;
		while (sent_count - start < PHASE_ITEMS) begin
			if (tty) begin
				line_sequence();
			end else begin
				framed_sequence();
			end
		end
		case ($urandom_range(2))
			0: begin
				send_eos();
			end
			1: begin
				repeat ($urandom_range(7, 1)) send_byte(8'($urandom()));
			end
			default: begin
			end
		endcase
		steady = 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// framed mode at the reset settings
		// empty frame on stderr gives a bare end marker at once
		send_header(STREAM_ERR, 32'd0);
		// stdout frame cut off by end of stream, extremes of the byte
		send_header(STREAM_OUT, 32'd3);
		send_byte(8'h00);
		send_byte(8'hff);
		send_eos();
		drain();

		// line mode: plain bytes, a newline, an empty line, an open line at the end
		set_mode(1'b1, MAX_PAYLOAD_RST);
		send_byte(8'hff);
		send_byte(NEWLINE_CHAR);
		send_byte(NEWLINE_CHAR);
		send_byte(8'h00);
		send_eos();
		send_eos();  // nothing open, so no item

		// random phases over the register extremes and a few limits in between
		random_phase(1'b0, 32'd5, 1'b0);
		random_phase(1'b1, 32'd5, 1'b0);
		random_phase(1'b0, 32'hffff_ffff, 1'b1);
		random_phase(1'b0, 32'd0, 1'b0);
		random_phase(1'b1, 32'd0, 1'b0);
		random_phase(1'b0, 32'd20, 1'b0);
		random_phase(1'b0, MAX_PAYLOAD_RST, 1'b0);

		drain();
		repeat (20) @(posedge clk);
		sb.close_run();
		if (sb.fails == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### sim.f
hdl/lsd_pkg.sv
hdl/lsd_core.sv
hdl/log_stream_deframer_top.sv
test/lsd_tb_pkg.sv
test/tb_log_stream_deframer_top.sv
